// File: rtl/core/ofdm_subcarrier_mapper_macros.svh
// Assertion helpers for the subcarrier mapper. They expect clk and rst_n in scope.
`ifndef OFDM_SUBCARRIER_MAPPER_MACROS_SVH
`define OFDM_SUBCARRIER_MAPPER_MACROS_SVH

`define OSM_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("osm same-cycle check failed");

`define OSM_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("osm next-cycle check failed");

`endif

// File: rtl/core/osm_pkg.sv
`timescale 1ns / 1ps

package osm_pkg;

    localparam int FFT_SIZE_DEF       = 64;
    localparam int MAX_PILOT_ROWS_DEF = 128;
    localparam int MAX_PILOTS_DEF     = 8;
    localparam int MAX_SYNC_WORDS_DEF = 4;
    localparam int SAMPLE_WIDTH_DEF   = 16;

    localparam int COMMAND_W        = 3;
    localparam int TABLE_ADDRESS_W  = 10;
    localparam int SYNC_SELECT_W    = 2;
    localparam int CARRIER_NUMBER_W = 6;
    localparam int CARRIER_KIND_W   = 2;
    localparam int MASK_W           = 64;
    localparam int ROW_COUNT_W      = 8;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 64;

    // Wide enough to hold the largest pilot table depth itself.
    localparam int TBL_ADDR_W = 12;

    localparam logic [COMMAND_W-1:0] CMD_DATA        = 3'd0;
    localparam logic [COMMAND_W-1:0] CMD_SYNC        = 3'd1;
    localparam logic [COMMAND_W-1:0] CMD_END_FRAME   = 3'd2;
    localparam logic [COMMAND_W-1:0] CMD_PILOT_WRITE = 3'd3;
    localparam logic [COMMAND_W-1:0] CMD_SYNC_WRITE  = 3'd4;

    localparam logic [CARRIER_KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [CARRIER_KIND_W-1:0] KIND_PILOT = 2'd1;
    localparam logic [CARRIER_KIND_W-1:0] KIND_NULL  = 2'd2;
    localparam logic [CARRIER_KIND_W-1:0] KIND_SYNC  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_DATA_MASK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PILOT_MASK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 2'd2;

    typedef struct packed {
        logic                  pilot_en;
        logic                  sync_en;
        logic [TBL_ADDR_W-1:0] addr;
    } tbl_write_t;

    typedef struct packed {
        logic                  en;
        logic                  from_sync;
        logic [TBL_ADDR_W-1:0] addr;
    } tbl_read_t;

endpackage

// File: rtl/core/ofdm_subcarrier_mapper.sv
// Channel   Direction  Handshake                    Beat contents
// item      in         item_valid / item_stall      command, sample, table address, sync select
// carrier   out        carrier_valid / carrier_stall one carrier: value, number, kind, last flag
// cfg       in         cfg_write                    cfg_index, cfg_data
//
// An item is taken while the sequencer is idle; then the sequencer issues one carrier per cycle,
// unless the output stalls, through the read stage, reading pilot and sync values from the tables.
// A sync symbol emits FFT_SIZE carriers; table writes and ignored items do not start the sequencer.
// Reset is asynchronous and active low; the tables hold no defined value until written.
// An output stall holds the output register and the read stage and pauses the sequencer.
`timescale 1ns / 1ps
`include "ofdm_subcarrier_mapper_macros.svh"

module ofdm_subcarrier_mapper
    import osm_pkg::*;
#(
    parameter int FFT_SIZE       = FFT_SIZE_DEF,
    parameter int MAX_PILOT_ROWS = MAX_PILOT_ROWS_DEF,
    parameter int MAX_PILOTS     = MAX_PILOTS_DEF,
    parameter int MAX_SYNC_WORDS = MAX_SYNC_WORDS_DEF,
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [COMMAND_W-1:0]             command,
    input  logic signed [SAMPLE_WIDTH-1:0]   sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0]   sample_imag,
    input  logic [TABLE_ADDRESS_W-1:0]       table_address,
    input  logic [SYNC_SELECT_W-1:0]         sync_select,

    output logic                             carrier_valid,
    input  logic                             carrier_stall,
    output logic signed [SAMPLE_WIDTH-1:0]   carrier_real,
    output logic signed [SAMPLE_WIDTH-1:0]   carrier_imag,
    output logic [CARRIER_NUMBER_W-1:0]      carrier_number,
    output logic [CARRIER_KIND_W-1:0]        carrier_kind,
    output logic                             symbol_last,

    input  logic                             cfg_write,
    input  logic [CFG_INDEX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data
);

    localparam int PILOT_DEPTH = MAX_PILOT_ROWS * MAX_PILOTS;
    localparam int SYNC_DEPTH  = MAX_SYNC_WORDS * FFT_SIZE;
    localparam int CAR_W       = $clog2(FFT_SIZE);
    localparam int ROW_W       = (MAX_PILOT_ROWS > 1) ? $clog2(MAX_PILOT_ROWS) : 1;
    localparam int SLOT_W      = $clog2(MAX_PILOTS + 1);
    localparam int CNT_W       = ROW_COUNT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SYNC
    } state_t;

    state_t                         state_reg, state_next;
    logic [MASK_W-1:0]              data_mask_reg, data_mask_next;
    logic [MASK_W-1:0]              pilot_mask_reg, pilot_mask_next;
    logic [ROW_COUNT_W-1:0]         row_count_reg, row_count_next;

    logic [CAR_W-1:0]               carrier_reg, carrier_next;
    logic [ROW_W-1:0]               row_reg, row_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;
    logic                           open_reg, open_next;
    logic                           fill_reg, fill_next;
    logic                           eof_reg, eof_next;
    logic [SYNC_SELECT_W-1:0]       sel_reg, sel_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_real_reg, sample_real_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_imag_reg, sample_imag_next;

    logic                           rd_valid_reg, rd_valid_next;
    logic                           rd_mem_reg, rd_mem_next;
    logic signed [SAMPLE_WIDTH-1:0] rd_real_reg, rd_real_next;
    logic signed [SAMPLE_WIDTH-1:0] rd_imag_reg, rd_imag_next;
    logic [CAR_W-1:0]               rd_number_reg, rd_number_next;
    logic [CARRIER_KIND_W-1:0]      rd_kind_reg, rd_kind_next;
    logic                           rd_last_reg, rd_last_next;

    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_real_reg, out_real_next;
    logic signed [SAMPLE_WIDTH-1:0] out_imag_reg, out_imag_next;
    logic [CAR_W-1:0]               out_number_reg, out_number_next;
    logic [CARRIER_KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic                           out_last_reg, out_last_next;

    logic [FFT_SIZE-1:0]            dm_eff;
    logic [FFT_SIZE-1:0]            pm_eff;
    logic [FFT_SIZE-1:0]            above_mask;
    logic                           more_data;
    logic                           accept;
    logic                           move;
    logic                           issue_ok;
    logic                           is_last;
    logic                           placed;
    logic                           sel_ok;
    logic [CNT_W-1:0]               cnt_eff;
    logic [CNT_W-1:0]               row_plus;
    logic [ROW_W-1:0]               row_adv;
    logic [TBL_ADDR_W-1:0]          pilot_addr;
    logic [TBL_ADDR_W-1:0]          sync_addr;
    logic [TBL_ADDR_W-1:0]          write_addr;
    tbl_write_t                     tbl_wr;
    tbl_read_t                      tbl_rd;
    logic [2*SAMPLE_WIDTH-1:0]      tbl_rdata;

    osm_tables #(
        .FFT_SIZE       (FFT_SIZE),
        .MAX_PILOT_ROWS (MAX_PILOT_ROWS),
        .MAX_PILOTS     (MAX_PILOTS),
        .MAX_SYNC_WORDS (MAX_SYNC_WORDS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_tables (
        .clk   (clk),
        .wr    (tbl_wr),
        .wdata ({sample_imag, sample_real}),
        .rd    (tbl_rd),
        .rdata (tbl_rdata)
    );

    assign dm_eff     = data_mask_reg[FFT_SIZE-1:0] & ~pilot_mask_reg[FFT_SIZE-1:0];
    assign pm_eff     = pilot_mask_reg[FFT_SIZE-1:0];
    assign above_mask = ({FFT_SIZE{1'b1}} << carrier_reg) << 1;
    assign more_data  = |(dm_eff & above_mask);
    assign is_last    = (carrier_reg == CAR_W'(FFT_SIZE - 1));

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign move       = rd_valid_reg && (!out_valid_reg || !carrier_stall);
    assign issue_ok   = !rd_valid_reg || move;
    assign sel_ok     = (4'(sync_select) < 4'(MAX_SYNC_WORDS));

    // A row count of zero acts as one; counts above the table height are clipped.
    assign cnt_eff  = (row_count_reg == '0) ? CNT_W'(1) :
                      (CNT_W'(row_count_reg) > CNT_W'(MAX_PILOT_ROWS)) ? CNT_W'(MAX_PILOT_ROWS) :
                      CNT_W'(row_count_reg);
    assign row_plus = CNT_W'(row_reg) + CNT_W'(1);
    assign row_adv  = (row_plus >= cnt_eff) ? '0 : row_plus[ROW_W-1:0];

    assign pilot_addr = TBL_ADDR_W'(row_reg) * TBL_ADDR_W'(MAX_PILOTS) + TBL_ADDR_W'(slot_reg);
    assign sync_addr  = TBL_ADDR_W'(sel_reg) * TBL_ADDR_W'(FFT_SIZE) + TBL_ADDR_W'(carrier_reg);
    assign write_addr = TBL_ADDR_W'(table_address);

    always_comb
    begin
        state_next       = state_reg;
        data_mask_next   = data_mask_reg;
        pilot_mask_next  = pilot_mask_reg;
        row_count_next   = row_count_reg;
        carrier_next     = carrier_reg;
        row_next         = row_reg;
        slot_next        = slot_reg;
        open_next        = open_reg;
        fill_next        = fill_reg;
        eof_next         = eof_reg;
        sel_next         = sel_reg;
        sample_real_next = sample_real_reg;
        sample_imag_next = sample_imag_reg;
        rd_valid_next    = rd_valid_reg;
        rd_mem_next      = rd_mem_reg;
        rd_real_next     = rd_real_reg;
        rd_imag_next     = rd_imag_reg;
        rd_number_next   = rd_number_reg;
        rd_kind_next     = rd_kind_reg;
        rd_last_next     = rd_last_reg;
        out_valid_next   = out_valid_reg;
        out_real_next    = out_real_reg;
        out_imag_next    = out_imag_reg;
        out_number_next  = out_number_reg;
        out_kind_next    = out_kind_reg;
        out_last_next    = out_last_reg;
        placed           = 1'b0;
        tbl_wr           = '0;
        tbl_rd           = '0;
        tbl_wr.addr      = write_addr;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_DATA_MASK:  data_mask_next  = cfg_data[MASK_W-1:0];
                REG_PILOT_MASK: pilot_mask_next = cfg_data[MASK_W-1:0];
                REG_ROW_COUNT:  row_count_next  = cfg_data[ROW_COUNT_W-1:0];
                default:        ;
            endcase
        end

        if (out_valid_reg && !carrier_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            out_valid_next  = 1'b1;
            out_real_next   = rd_mem_reg ? tbl_rdata[SAMPLE_WIDTH-1:0] : rd_real_reg;
            out_imag_next   = rd_mem_reg ? tbl_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : rd_imag_reg;
            out_number_next = rd_number_reg;
            out_kind_next   = rd_kind_reg;
            out_last_next   = rd_last_reg;
            rd_valid_next   = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_DATA:
                        begin
                            if (open_reg || (|dm_eff))
                            begin
                                fill_next        = 1'b1;
                                eof_next         = 1'b0;
                                sample_real_next = sample_real;
                                sample_imag_next = sample_imag;
                                open_next        = 1'b1;
                                if (!open_reg)
                                begin
                                    carrier_next = '0;
                                    slot_next    = '0;
                                end
                                state_next = ST_SWEEP;
                            end
                        end
                        CMD_SYNC:
                        begin
                            if (!open_reg && sel_ok)
                            begin
                                sel_next     = sync_select;
                                carrier_next = '0;
                                state_next   = ST_SYNC;
                            end
                        end
                        CMD_END_FRAME:
                        begin
                            if (open_reg)
                            begin
                                fill_next  = 1'b0;
                                eof_next   = 1'b1;
                                state_next = ST_SWEEP;
                            end
                            else
                            begin
                                row_next  = '0;
                                slot_next = '0;
                            end
                        end
                        CMD_PILOT_WRITE:
                        begin
                            tbl_wr.pilot_en = (write_addr < TBL_ADDR_W'(PILOT_DEPTH));
                        end
                        CMD_SYNC_WRITE:
                        begin
                            tbl_wr.sync_en = (write_addr < TBL_ADDR_W'(SYNC_DEPTH));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SWEEP:
            begin
                if (issue_ok)
                begin
                    rd_valid_next  = 1'b1;
                    rd_number_next = carrier_reg;
                    rd_last_next   = is_last;
                    rd_mem_next    = 1'b0;
                    rd_real_next   = '0;
                    rd_imag_next   = '0;
                    if (pm_eff[carrier_reg])
                    begin
                        rd_kind_next = KIND_PILOT;
                        // Pilots past the table width in one symbol stay zero.
                        if (slot_reg < SLOT_W'(MAX_PILOTS))
                        begin
                            tbl_rd.en   = 1'b1;
                            tbl_rd.addr = pilot_addr;
                            rd_mem_next = 1'b1;
                            slot_next   = slot_reg + SLOT_W'(1);
                        end
                    end
                    else if (dm_eff[carrier_reg])
                    begin
                        rd_kind_next = KIND_DATA;
                        if (fill_reg)
                        begin
                            rd_real_next = sample_real_reg;
                            rd_imag_next = sample_imag_reg;
                            placed       = 1'b1;
                        end
                    end
                    else
                    begin
                        rd_kind_next = KIND_NULL;
                    end

                    if (is_last)
                    begin
                        open_next    = 1'b0;
                        carrier_next = '0;
                        slot_next    = '0;
                        row_next     = eof_reg ? '0 : row_adv;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        carrier_next = carrier_reg + CAR_W'(1);
                        if (placed && more_data)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_SYNC:
            begin
                if (issue_ok)
                begin
                    tbl_rd.en        = 1'b1;
                    tbl_rd.from_sync = 1'b1;
                    tbl_rd.addr      = sync_addr;
                    rd_valid_next    = 1'b1;
                    rd_mem_next      = 1'b1;
                    rd_number_next   = carrier_reg;
                    rd_kind_next     = KIND_SYNC;
                    rd_last_next     = is_last;
                    if (is_last)
                    begin
                        carrier_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        carrier_next = carrier_reg + CAR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            data_mask_reg   <= '0;
            pilot_mask_reg  <= '0;
            row_count_reg   <= ROW_COUNT_W'(1);
            carrier_reg     <= '0;
            row_reg         <= '0;
            slot_reg        <= '0;
            open_reg        <= 1'b0;
            fill_reg        <= 1'b0;
            eof_reg         <= 1'b0;
            sel_reg         <= '0;
            sample_real_reg <= '0;
            sample_imag_reg <= '0;
            rd_valid_reg    <= 1'b0;
            rd_mem_reg      <= 1'b0;
            rd_real_reg     <= '0;
            rd_imag_reg     <= '0;
            rd_number_reg   <= '0;
            rd_kind_reg     <= KIND_NULL;
            rd_last_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_real_reg    <= '0;
            out_imag_reg    <= '0;
            out_number_reg  <= '0;
            out_kind_reg    <= KIND_NULL;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            data_mask_reg   <= data_mask_next;
            pilot_mask_reg  <= pilot_mask_next;
            row_count_reg   <= row_count_next;
            carrier_reg     <= carrier_next;
            row_reg         <= row_next;
            slot_reg        <= slot_next;
            open_reg        <= open_next;
            fill_reg        <= fill_next;
            eof_reg         <= eof_next;
            sel_reg         <= sel_next;
            sample_real_reg <= sample_real_next;
            sample_imag_reg <= sample_imag_next;
            rd_valid_reg    <= rd_valid_next;
            rd_mem_reg      <= rd_mem_next;
            rd_real_reg     <= rd_real_next;
            rd_imag_reg     <= rd_imag_next;
            rd_number_reg   <= rd_number_next;
            rd_kind_reg     <= rd_kind_next;
            rd_last_reg     <= rd_last_next;
            out_valid_reg   <= out_valid_next;
            out_real_reg    <= out_real_next;
            out_imag_reg    <= out_imag_next;
            out_number_reg  <= out_number_next;
            out_kind_reg    <= out_kind_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign carrier_valid  = out_valid_reg;
    assign carrier_real   = out_real_reg;
    assign carrier_imag   = out_imag_reg;
    assign carrier_number = CARRIER_NUMBER_W'(out_number_reg);
    assign carrier_kind   = out_kind_reg;
    assign symbol_last    = out_last_reg;

    `OSM_CHECK_NOW(a_last_is_top_carrier, carrier_valid && symbol_last, carrier_number == CARRIER_NUMBER_W'(FFT_SIZE - 1))
    `OSM_CHECK_NOW(a_null_is_zero, carrier_valid && carrier_kind == KIND_NULL, carrier_real == '0 && carrier_imag == '0)
    `OSM_CHECK_NOW(a_sync_needs_closed, state_reg == ST_SYNC, !open_reg)
    `OSM_CHECK_NOW(a_closed_slot_clear, !open_reg, slot_reg == '0)
    `OSM_CHECK_NEXT(a_move_fills_output, move, out_valid_reg)

endmodule

// File: rtl/core/osm_tables.sv
`timescale 1ns / 1ps

module osm_tables
    import osm_pkg::*;
#(
    parameter int FFT_SIZE       = FFT_SIZE_DEF,
    parameter int MAX_PILOT_ROWS = MAX_PILOT_ROWS_DEF,
    parameter int MAX_PILOTS     = MAX_PILOTS_DEF,
    parameter int MAX_SYNC_WORDS = MAX_SYNC_WORDS_DEF,
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF
)
(
    input  logic                      clk,
    input  tbl_write_t                wr,
    input  logic [2*SAMPLE_WIDTH-1:0] wdata,
    input  tbl_read_t                 rd,
    output logic [2*SAMPLE_WIDTH-1:0] rdata
);

    localparam int PILOT_DEPTH = MAX_PILOT_ROWS * MAX_PILOTS;
    localparam int SYNC_DEPTH  = MAX_SYNC_WORDS * FFT_SIZE;
    localparam int PILOT_AW    = (PILOT_DEPTH > 1) ? $clog2(PILOT_DEPTH) : 1;
    localparam int SYNC_AW     = (SYNC_DEPTH > 1) ? $clog2(SYNC_DEPTH) : 1;

    logic [2*SAMPLE_WIDTH-1:0] pilot_mem [PILOT_DEPTH];
    logic [2*SAMPLE_WIDTH-1:0] sync_mem [SYNC_DEPTH];
    logic [2*SAMPLE_WIDTH-1:0] pilot_q_reg;
    logic [2*SAMPLE_WIDTH-1:0] sync_q_reg;
    logic                      from_sync_reg;

    always_ff @(posedge clk)
    begin
        if (wr.pilot_en)
        begin
            pilot_mem[wr.addr[PILOT_AW-1:0]] <= wdata;
        end
        if (rd.en && !rd.from_sync)
        begin
            pilot_q_reg <= pilot_mem[rd.addr[PILOT_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.sync_en)
        begin
            sync_mem[wr.addr[SYNC_AW-1:0]] <= wdata;
        end
        if (rd.en && rd.from_sync)
        begin
            sync_q_reg <= sync_mem[rd.addr[SYNC_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            from_sync_reg <= rd.from_sync;
        end
    end

    assign rdata = from_sync_reg ? sync_q_reg : pilot_q_reg;

endmodule
